// ----- rtl/tfd_pkg.sv -----
// Shared constants and types for the telemetry frame deframer.
// No dependencies; used by every module of the block.
package tfd_pkg;

  localparam logic [7:0] HDR0 = 8'hEE;
  localparam logic [7:0] HDR1 = 8'h81;
  localparam logic [7:0] HDR2 = 8'h22;

  localparam int FRAME_LEN  = 34;
  localparam int BODY_FIRST = 3;
  localparam int BODY_LEN   = 30;   // frame bytes 3..32 kept
  localparam int POS_W      = 6;

  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(BODY_FIRST);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

  // gps_time occupies body indexes 18..23 (frame bytes 21..26), big-endian
  localparam int TIME_LO = 18;
  localparam int TIME_HI = 23;

  localparam int IN_W  = 8;
  localparam int OUT_W = 8 * BODY_LEN;  // 240 bits, already whole bytes

  typedef logic [7:0]       byte_t;
  typedef logic [OUT_W-1:0] frame_data_t;

  typedef struct packed {
    logic        valid;
    frame_data_t data;
  } frame_t;

endpackage

// ----- rtl/tfd_framer.sv -----
// Header matcher, frame byte counter and body shift line.
// Depends on tfd_pkg; emits one packed frame on the beat that carries byte 33.
module tfd_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  tfd_pkg::byte_t  byte_in,
  output tfd_pkg::frame_t frame
);

  typedef enum logic [1:0] {
    HUNT,
    GOT_HDR0,
    GOT_HDR1,
    BODY
  } stage_t;

  stage_t                        stage_r, stage_nxt;
  logic [tfd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [tfd_pkg::POS_W-1:0]     pos_eff;
  tfd_pkg::byte_t                body_r [tfd_pkg::BODY_LEN];
  logic                          shift_en;
  logic                          last_byte;

  always_comb begin
    if (pos_r < tfd_pkg::POS_FIRST || pos_r > tfd_pkg::POS_LAST) begin
      pos_eff = tfd_pkg::POS_FIRST;
    end else begin
      pos_eff = pos_r;
    end
  end

  always_comb begin
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    shift_en  = 1'b0;
    last_byte = 1'b0;
    case (stage_r)
      GOT_HDR0: begin
        if (byte_in == tfd_pkg::HDR1) begin
          stage_nxt = GOT_HDR1;
        end else begin
          stage_nxt = (byte_in == tfd_pkg::HDR0) ? GOT_HDR0 : HUNT;
        end
      end
      GOT_HDR1: begin
        if (byte_in == tfd_pkg::HDR2) begin
          stage_nxt = BODY;
          pos_nxt   = tfd_pkg::POS_FIRST;
        end else begin
          stage_nxt = (byte_in == tfd_pkg::HDR0) ? GOT_HDR0 : HUNT;
        end
      end
      BODY: begin
        if (pos_eff == tfd_pkg::POS_LAST) begin
          last_byte = 1'b1;
          stage_nxt = HUNT;
          pos_nxt   = '0;
        end else begin
          shift_en = 1'b1;
          pos_nxt  = pos_eff + 1'b1;
        end
      end
      default: begin
        stage_nxt = (byte_in == tfd_pkg::HDR0) ? GOT_HDR0 : HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= HUNT;
      pos_r   <= '0;
    end else if (byte_valid) begin
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // oldest body byte (frame byte 3) ends up at index 0
  always_ff @(posedge clk) begin
    if (byte_valid && shift_en) begin
      for (int i = 0; i < tfd_pkg::BODY_LEN - 1; i++) begin
        body_r[i] <= body_r[i+1];
      end
      body_r[tfd_pkg::BODY_LEN-1] <= byte_in;
    end
  end

  // little-endian fields pass straight through; gps_time is byte-reversed
  always_comb begin
    frame.valid = byte_valid && last_byte;
    for (int k = 0; k < tfd_pkg::BODY_LEN; k++) begin
      if (k < tfd_pkg::TIME_LO || k > tfd_pkg::TIME_HI) begin
        frame.data[8*k +: 8] = body_r[k];
      end else begin
        frame.data[8*k +: 8] = body_r[tfd_pkg::TIME_LO + tfd_pkg::TIME_HI - k];
      end
    end
  end

endmodule

// ----- rtl/tfd_outbuf.sv -----
// Output register with a skid stage for the frame result channel.
// Depends on tfd_pkg; accepts one frame per cycle while the skid is empty.
module tfd_outbuf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tfd_pkg::frame_t          frame,
  output logic                     room,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tfd_pkg::frame_data_t     out_data
);

  logic                 main_vld_r, main_vld_nxt;
  logic                 skid_vld_r, skid_vld_nxt;
  tfd_pkg::frame_data_t main_r;
  tfd_pkg::frame_data_t skid_r;
  logic                 take;
  logic                 load_main;
  logic                 load_skid;
  logic                 move_skid;

  assign take      = main_vld_r && out_ready;
  assign move_skid = take && skid_vld_r;
  assign load_main = frame.valid && (!main_vld_r || take) && !skid_vld_r;
  assign load_skid = frame.valid && main_vld_r && !take;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (take) begin
      main_vld_nxt = 1'b0;
    end
    if (load_main || move_skid) begin
      main_vld_nxt = 1'b1;
    end
    if (move_skid) begin
      skid_vld_nxt = 1'b0;
    end
    if (load_skid) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      main_r <= skid_r;
    end else if (load_main) begin
      main_r <= frame.data;
    end
    if (load_skid) begin
      skid_r <= frame.data;
    end
  end

  assign room      = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

// ----- rtl/telemetry_frame_deframer.sv -----
// Telemetry frame deframer: takes one received byte per beat, finds EE 81 22
// and emits the 34-byte frame's payload fields as one result beat. Bytes are
// taken one per cycle while in_tready is high; byte 33 registers the result.
// in_tready drops only while both the output register and its skid stage hold
// a frame. Header bytes inside a frame body are not searched; byte 33 and any
// checksum are not checked. Depends on tfd_pkg, tfd_framer and tfd_outbuf.
module telemetry_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tfd_pkg::IN_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] roll, [31:16] pitch, [47:32] yaw, [79:48] latitude,
  // [111:80] longitude, [127:112] gps_altitude, [143:128] relative_altitude,
  // [191:144] gps_time, [207:192] east_speed, [223:208] north_speed,
  // [239:224] up_speed
  output logic [tfd_pkg::OUT_W-1:0]   out_tdata
);

  tfd_pkg::frame_t frame;
  logic            room;
  logic            beat;

  assign in_tready = room;
  assign beat      = in_tvalid && room;

  tfd_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (beat),
    .byte_in    (in_tdata),
    .frame      (frame)
  );

  tfd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
